### rtl/core/ohash_pkg.sv
// Package for the one-at-a-time byte hash: shift constants, register
// indexes and the mix-to-finalize beat type. No dependencies.
`timescale 1ns / 1ps

package ohash_pkg;

   localparam int HASH_W  = 64;
   localparam int NARROW_W = 32;
   localparam int BYTE_W  = 8;

   // 32-bit scheme
   localparam int N_MIX_SHL = 10;
   localparam int N_MIX_SHR = 6;
   localparam int N_FIN_SHL_A = 3;
   localparam int N_FIN_SHR = 11;
   localparam int N_FIN_SHL_B = 15;

   // 64-bit variant
   localparam int W_MIX_SHL = 13;
   localparam int W_MIX_SHR = 3;
   localparam int W_FIN_SHL_A = 3;
   localparam int W_FIN_SHR = 23;
   localparam int W_FIN_SHL_B = 34;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MODE = 1'd1;

   // mixed hash handed to the finalizer
   typedef struct packed {
      logic              wide;
      logic [HASH_W-1:0] hash;
   } fin_beat_type;

endpackage

### rtl/core/ohash_mix.sv
// Input register and running-hash state of the one-at-a-time byte hash.
// Mixes one byte per cycle, a last beat only when fin_ready; hands the mixed hash of a last beat onward.
// Depends on ohash_pkg.
`timescale 1ns / 1ps

module ohash_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ohash_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                        req_byte_present,
   input  logic                        req_last_byte,
   input  logic [ohash_pkg::HASH_W-1:0] seed,
   input  logic                        wide_mode,
   output logic                        fin_valid,
   input  logic                        fin_ready,
   output ohash_pkg::fin_beat_type     fin_beat
);
   import ohash_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_present_ff;
   logic              s1_last_ff;
   logic              s1_go;
   logic              s1_idle;

   logic [HASH_W-1:0] run_ff, run_in;
   logic              mid_ff, mid_in;

   logic [HASH_W-1:0]   base;
   logic [HASH_W-1:0]   w_a, w_b, w_c;
   logic [NARROW_W-1:0] n_a, n_b, n_c;
   logic [HASH_W-1:0]   mixed;

   // idle beats carry neither byte nor last: they only drain
   assign s1_idle   = !s1_present_ff && !s1_last_ff;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || fin_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff    <= req_byte_value;
         s1_present_ff <= req_byte_present;
         s1_last_ff    <= req_last_byte;
      end
   end

   // message start loads the seed
   assign base = mid_ff ? run_ff : seed;

   always_comb begin
      w_a = base + {{(HASH_W-BYTE_W){1'b0}}, s1_byte_ff};
      w_b = w_a + (w_a << W_MIX_SHL);
      w_c = w_b + (w_b >> W_MIX_SHR);
      n_a = base[NARROW_W-1:0] + {{(NARROW_W-BYTE_W){1'b0}}, s1_byte_ff};
      n_b = n_a + (n_a << N_MIX_SHL);
      n_c = n_b + (n_b >> N_MIX_SHR);
      if (wide_mode) begin
         mixed = s1_present_ff ? w_c : base;
      end else begin
         mixed = {{(HASH_W-NARROW_W){1'b0}},
                  (s1_present_ff ? n_c : base[NARROW_W-1:0])};
      end
   end

   always_comb begin
      run_in = run_ff;
      mid_in = mid_ff;
      if (s1_go && !s1_idle) begin
         run_in = mixed;
         mid_in = !s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         mid_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         mid_ff <= mid_in;
      end
   end

   assign fin_valid     = s1_valid_ff && s1_last_ff;
   assign fin_beat.wide = wide_mode;
   assign fin_beat.hash = mixed;

   a_idle_keeps_state: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_idle |=> $stable(run_ff) && $stable(mid_ff))
      else $error("idle beat changed hash state");

   a_last_ends_msg: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> !mid_ff)
      else $error("message still open after last beat");

   a_narrow_upper_clear: assert property (@(posedge clock) disable iff (reset)
      s1_go && !s1_idle && !wide_mode |=> run_ff[HASH_W-1:NARROW_W] == '0)
      else $error("32-bit beat left upper hash bits set");

endmodule

### rtl/core/ohash_fin.sv
// Finalize stage of the one-at-a-time byte hash: holding register for the
// mixed hash, finalize shifts and the result register. Depends on ohash_pkg.
`timescale 1ns / 1ps

module ohash_fin (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fin_valid,
   output logic                         fin_ready,
   input  ohash_pkg::fin_beat_type      fin_beat,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ohash_pkg::HASH_W-1:0] rsp_hash_value
);
   import ohash_pkg::*;

   logic         s2_valid_ff, s2_valid_in;
   fin_beat_type s2_beat_ff;
   logic         s2_go;

   logic              s3_valid_ff, s3_valid_in;
   logic [HASH_W-1:0] s3_hash_ff;
   logic              s3_wide_ff;
   logic              s3_ready;

   logic [HASH_W-1:0]   w_a, w_b, w_c;
   logic [NARROW_W-1:0] n_a, n_b, n_c;
   logic [HASH_W-1:0]   final_hash;

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_go     = s2_valid_ff && s3_ready;
   assign fin_ready = !s2_valid_ff || s3_ready;

   assign s2_valid_in = fin_ready ? fin_valid : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         s2_beat_ff <= fin_beat;
      end
   end

   always_comb begin
      w_a = s2_beat_ff.hash + (s2_beat_ff.hash << W_FIN_SHL_A);
      w_b = w_a ^ (w_a >> W_FIN_SHR);
      w_c = w_b + (w_b << W_FIN_SHL_B);
      n_a = s2_beat_ff.hash[NARROW_W-1:0] + (s2_beat_ff.hash[NARROW_W-1:0] << N_FIN_SHL_A);
      n_b = n_a ^ (n_a >> N_FIN_SHR);
      n_c = n_b + (n_b << N_FIN_SHL_B);
      final_hash = s2_beat_ff.wide ? w_c : {{(HASH_W-NARROW_W){1'b0}}, n_c};
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_hash_ff <= final_hash;
         s3_wide_ff <= s2_beat_ff.wide;
      end
   end

   assign rsp_valid      = s3_valid_ff;
   assign rsp_hash_value = s3_hash_ff;

   a_narrow_zero_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !s3_wide_ff |-> rsp_hash_value[HASH_W-1:NARROW_W] == '0)
      else $error("32-bit result not zero-extended");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result dropped or changed while stalled");

   a_s2_held: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(s2_beat_ff))
      else $error("finalize holding register lost its beat");

endmodule

### rtl/core/one_at_a_time_byte_hash.sv
// Top level of the one-at-a-time byte hash: configuration registers and
// the mix and finalize stages. Depends on ohash_pkg, ohash_mix, ohash_fin.
//
//   port group  dir  handshake            payload
//   req_*       in   req_valid/req_ready  byte_value, byte_present, last_byte
//   rsp_*       out  rsp_valid/rsp_ready  hash_value
//   csr_*       in   csr_write_en         csr_index, csr_wdata
//
// One beat per cycle sustained unless a last beat is held by a stalled rsp; the running-hash update feeds run_ff back.
// A last beat's hash passes the input register, the finalize holding register and
// the result register, in that order, before it is on rsp.
// Synchronous reset clears seed, mode, running hash and all valid flags.
// A stalled rsp backs up through the stages; non-last beats keep draining.
`timescale 1ns / 1ps

module one_at_a_time_byte_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ohash_pkg::BYTE_W-1:0]    req_byte_value,
   input  logic                            req_byte_present,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ohash_pkg::HASH_W-1:0]    rsp_hash_value,
   input  logic                            csr_write_en,
   input  logic [ohash_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ohash_pkg::HASH_W-1:0]    csr_wdata
);
   import ohash_pkg::*;

   logic [HASH_W-1:0] seed_ff, seed_in;
   logic              wide_mode_ff, wide_mode_in;

   logic         fin_valid;
   logic         fin_ready;
   fin_beat_type fin_beat;

   always_comb begin
      seed_in      = seed_ff;
      wide_mode_in = wide_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SEED:      seed_in = csr_wdata;
            CSR_WIDE_MODE: wide_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         wide_mode_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         wide_mode_ff <= wide_mode_in;
      end
   end

   ohash_mix u_mix (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .seed             (seed_ff),
      .wide_mode        (wide_mode_ff),
      .fin_valid        (fin_valid),
      .fin_ready        (fin_ready),
      .fin_beat         (fin_beat)
   );

   ohash_fin u_fin (
      .clock          (clock),
      .reset          (reset),
      .fin_valid      (fin_valid),
      .fin_ready      (fin_ready),
      .fin_beat       (fin_beat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

### sim/tb_top.sv
// Testbench for one_at_a_time_byte_hash: directed and random byte streams,
// checked against a behavioral hash predictor. Depends on ohash_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import ohash_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 6;  // pipeline is three deep
   localparam int RANDOM_BEATS = 1750;

   class oaat_scoreboard;
      logic [HASH_W-1:0] seed;
      logic              wide;
      logic [HASH_W-1:0] running_hash;
      logic              in_message;
      logic [HASH_W-1:0] expected_hashes[$];
      int                errors;

      function new();
         seed = '0;
         wide = 1'b0;
         running_hash = '0;
         in_message = 1'b0;
         errors = 0;
      endfunction

      function logic [NARROW_W-1:0] narrow_mix(logic [NARROW_W-1:0] h, logic [BYTE_W-1:0] b);
         h = h + b;
         h = h + (h << N_MIX_SHL);
         h = h + (h >> N_MIX_SHR);
         return h;
      endfunction

      function logic [NARROW_W-1:0] narrow_final(logic [NARROW_W-1:0] h);
         h = h + (h << N_FIN_SHL_A);
         h = h ^ (h >> N_FIN_SHR);
         h = h + (h << N_FIN_SHL_B);
         return h;
      endfunction

      function logic [HASH_W-1:0] wide_mix(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
         h = h + b;
         h = h + (h << W_MIX_SHL);
         h = h + (h >> W_MIX_SHR);
         return h;
      endfunction

      function logic [HASH_W-1:0] wide_final(logic [HASH_W-1:0] h);
         h = h + (h << W_FIN_SHL_A);
         h = h ^ (h >> W_FIN_SHR);
         h = h + (h << W_FIN_SHL_B);
         return h;
      endfunction

      // accepted request beat
      function void absorb_beat(logic [BYTE_W-1:0] b, logic has_byte, logic is_last);
         logic [NARROW_W-1:0] h32;
         if (!has_byte && !is_last)
            return;
         if (!in_message)
            running_hash = seed;
         if (wide) begin
            if (has_byte)
               running_hash = wide_mix(running_hash, b);
         end else begin
            // narrow beat drops the upper half
            h32 = running_hash[NARROW_W-1:0];
            if (has_byte)
               h32 = narrow_mix(h32, b);
            running_hash = {32'h0, h32};
         end
         if (!is_last) begin
            in_message = 1'b1;
            return;
         end
         if (wide)
            expected_hashes.push_back(wide_final(running_hash));
         else
            expected_hashes.push_back({32'h0, narrow_final(running_hash[NARROW_W-1:0])});
         in_message = 1'b0;
      endfunction

      // accepted response beat
      function void match_hash(logic [HASH_W-1:0] got);
         logic [HASH_W-1:0] want;
         if (expected_hashes.size() == 0) begin
            $error("hash_value: expected none, got %h", got);
            errors++;
            return;
         end
         want = expected_hashes.pop_front();
         if (got !== want) begin
            $error("hash_value: expected %h, got %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_byte_value;
   logic                  req_byte_present;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [HASH_W-1:0]     rsp_hash_value;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [HASH_W-1:0]     csr_wdata;

   oaat_scoreboard sb;
   int  sender_idle_pct;
   int  rcv_stall_pct;
   bit  rsp_hold;
   int  cycle_count;
   int  counted_beats;

   one_at_a_time_byte_hash uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.absorb_beat(req_byte_value, req_byte_present, req_last_byte);
         if (rsp_valid && rsp_ready)
            sb.match_hash(rsp_hash_value);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= rsp_hold ? 1'b0 : ($urandom_range(0, 99) >= rcv_stall_pct);
   end

   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic has_byte,
                            input logic is_last);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(0, 99) < sender_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_byte_present <= has_byte;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, wait for all hashes, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_hashes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SEED:      sb.seed = data;
         CSR_WIDE_MODE: sb.wide = data[0];
         default: ;
      endcase
   endtask

   // len bytes; an absent-byte beat closes the message when absent_end is set
   task automatic send_message(input int len, input bit absent_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            counted_beats++;
         end
         send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !absent_end);
         counted_beats++;
      end
      if (absent_end) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         counted_beats++;
      end
   endtask

   task automatic random_messages(input int beats);
      int start;
      int pick;
      start = counted_beats;
      while (counted_beats - start < beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            send_message(0, 1'b1);
         else if (pick < 14)
            send_message($urandom_range(9, 40), $urandom_range(0, 99) < 15);
         else
            send_message($urandom_range(1, 8), $urandom_range(0, 99) < 15);
      end
   endtask

   initial begin
      logic [HASH_W-1:0] seed_val;
      int phase;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_value = '0;
      req_byte_present = 1'b0;
      req_last_byte = 1'b0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_SEED;
      csr_wdata = '0;
      sender_idle_pct = 0;
      rcv_stall_pct = 0;
      rsp_hold = 1'b0;
      cycle_count = 0;
      counted_beats = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed, reset config: narrow mode, seed zero
      send_beat(8'h00, 1'b0, 1'b0);    // idle beat outside a message
      send_beat(8'h00, 1'b0, 1'b1);    // empty message
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h80, 1'b1, 1'b0);
      send_beat(8'h01, 1'b1, 1'b0);
      send_beat(8'h55, 1'b0, 1'b1);    // absent byte closes the message
      send_beat(8'h7F, 1'b1, 1'b0);
      send_beat(8'hAA, 1'b0, 1'b0);    // idle beat inside a message
      send_beat(8'hFE, 1'b1, 1'b1);
      settle();
      write_csr(CSR_SEED, '1);
      write_csr(CSR_WIDE_MODE, 64'd1);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b1);
      // new seed lands mid-message; applies only from the next message
      send_beat(8'h5A, 1'b1, 1'b0);
      settle();
      write_csr(CSR_SEED, {$urandom, $urandom});
      send_beat(8'hA5, 1'b1, 1'b1);
      send_beat(8'h3C, 1'b1, 1'b1);
      // mode flips mid-message, both directions
      send_beat(8'hC3, 1'b1, 1'b0);
      settle();
      write_csr(CSR_WIDE_MODE, 64'd0);
      send_beat(8'h99, 1'b1, 1'b0);
      settle();
      write_csr(CSR_WIDE_MODE, 64'd1);
      send_beat(8'h66, 1'b1, 1'b1);
      settle();
      write_csr(CSR_SEED, '1);
      write_csr(CSR_WIDE_MODE, 64'd0);
      send_beat(8'h00, 1'b0, 1'b1);
      settle();

      counted_beats = 0;
      phase = 0;
      while (counted_beats < RANDOM_BEATS) begin
         case (phase % 5)
            0: seed_val = '0;
            1: seed_val = '1;
            2: seed_val = 64'h0000_0000_FFFF_FFFF;
            3: seed_val = {$urandom, $urandom};
            default: seed_val = {$urandom, 32'h0};
         endcase
         write_csr(CSR_SEED, seed_val);
         write_csr(CSR_WIDE_MODE, (phase % 3 == 2) ? 64'($urandom_range(0, 1))
                                                    : 64'(phase % 2));
         case (phase % 4)
            0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; rcv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcv_stall_pct = 73; end
            default: begin sender_idle_pct = 26; rcv_stall_pct = 26; end
         endcase
         if (phase == 4) begin
            // long receiver hold-off so the pipe backs up into req_ready
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  rsp_hold = 1'b0;
               end
               random_messages(110);
            join
         end else begin
            random_messages(110);
         end
         settle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_hashes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/ohash_pkg.sv
rtl/core/ohash_mix.sv
rtl/core/ohash_fin.sv
rtl/core/one_at_a_time_byte_hash.sv
sim/tb_top.sv
